@@ sv/fwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fwsc_pkg
// shared types and codes for the second-chance cache core
// ----------------------------------------------------------------------------
package fwsc_pkg;

    // outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_CLEAN = 2'd1;
    localparam logic [1:0] OUT_DIRTY = 2'd2;

    // request as queued between front and back
    typedef struct packed {
        logic        is_write;
        logic [19:0] word_addr;
        logic [31:0] wval;
    } fwsc_req_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOK,
        ST_HITRD,
        ST_VICTIM,
        ST_WB_RD,
        ST_WB_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_FINISH,
        ST_RDOUT,
        ST_DONE
    } fwsc_state_t;

endpackage

@@ sv/four_way_second_chance_cache_core.sv @@
// ----------------------------------------------------------------------------
// four_way_second_chance_cache_core
// write-back, write-allocate set-associative cache with clock replacement
// ----------------------------------------------------------------------------
// A hit reads the tags one way at a time from the tag memory, then does a
// single-port data read. A clean miss adds the victim walk and the refill and
// tag update; a dirty miss adds a writeback of the victim line before the
// refill. The back end starts the next request only after the previous result
// transfer has been taken. After reset a clearing pass zeroes the backing, tag
// and pointer memories; no request leaves the queue until it ends. A two-entry
// queue in front takes up to two request transfers while the back end is busy.
module four_way_second_chance_cache_core #(
    parameter int WAYS         = 4,
    parameter int SETS         = 1024,
    parameter int LINE_WORDS   = 16,
    parameter int MEMORY_WORDS = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // mode, byte_address, write_value, zero pad
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [39:0] m_axis_tdata   // read_value, outcome, zero pad
);
    import fwsc_pkg::*;

    fwsc_req_t in_req, q_req;
    logic      q_valid, q_pop;
    logic [31:0] rv;
    logic [1:0]  oc;

    assign in_req.is_write  = s_axis_tdata[0];
    assign in_req.word_addr = s_axis_tdata[22:3];
    assign in_req.wval      = s_axis_tdata[54:23];

    fwsc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    fwsc_back #(.WAYS(WAYS), .SETS(SETS), .LINE_WORDS(LINE_WORDS),
                .MEMORY_WORDS(MEMORY_WORDS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_value(rv), .res_outcome(oc)
    );

    assign m_axis_tdata = {6'd0, oc, rv};
endmodule

@@ sv/fwsc_front.sv @@
// ----------------------------------------------------------------------------
// fwsc_front
// accepts request transfers and holds them in a short queue for the back end
// ----------------------------------------------------------------------------
module fwsc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwsc_pkg::fwsc_req_t in_req,
    output logic                q_valid,
    input  logic                q_pop,
    output fwsc_pkg::fwsc_req_t q_req
);
    import fwsc_pkg::*;

    fwsc_req_t  slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rp_reg];

    // two-entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
        if (push) slot_reg[wp_reg] <= in_req;
    end
endmodule

@@ sv/fwsc_back.sv @@
// ----------------------------------------------------------------------------
// fwsc_back
// tag lookup, second-chance victim walk, writeback and refill sequencer
// ----------------------------------------------------------------------------
module fwsc_back #(
    parameter int WAYS         = 4,
    parameter int SETS         = 1024,
    parameter int LINE_WORDS   = 16,
    parameter int MEMORY_WORDS = 1048576
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  fwsc_pkg::fwsc_req_t q_req,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [31:0]         res_value,
    output logic [1:0]          res_outcome
);
    import fwsc_pkg::*;

    localparam int WB   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SB   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OB   = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int MB   = $clog2(MEMORY_WORDS);
    localparam int SETL = $clog2(SETS);
    localparam int OFFL = $clog2(LINE_WORDS);
    localparam int TB   = (20 - SETL - OFFL > 0) ? 20 - SETL - OFFL : 1;
    localparam int LB   = (WAYS * SETS > 1) ? $clog2(WAYS * SETS) : 1;
    localparam int DB   = (WAYS * SETS * LINE_WORDS > 1) ? $clog2(WAYS * SETS * LINE_WORDS) : 1;
    localparam int CB   = (MB > LB) ? MB + 1 : LB + 1;
    localparam int TAGW = TB + 3;

    // memories
    logic [TAGW-1:0] tag_mem [WAYS*SETS];
    logic [31:0]     data_mem [WAYS*SETS*LINE_WORDS];
    logic [31:0]     back_mem [MEMORY_WORDS];
    logic [WB-1:0]   ptr_mem  [SETS];

    fwsc_state_t state_reg, state_next;
    fwsc_req_t   req_reg;
    logic [CB-1:0] clr_reg;
    logic [WB-1:0] way_reg, wcnt_reg;
    logic [OB:0]   idx_reg;
    logic [TAGW-1:0] line_reg [WAYS];
    logic [31:0]   drd_reg, brd_reg, res_v_reg;
    logic [1:0]    res_o_reg;
    logic          res_valid_reg;
    logic [WB-1:0] ptr_reg;

    logic [TB-1:0]   r_tag;
    logic [SB-1:0]   r_set;
    logic [OB-1:0]   r_off;
    logic [MB-1:0]   r_line_base;

    assign r_off = (LINE_WORDS > 1) ? OB'(req_reg.word_addr) : '0;
    assign r_set = (SETS > 1) ? SB'(req_reg.word_addr >> OFFL) : '0;
    assign r_tag = TB'(req_reg.word_addr >> (OFFL + SETL));
    assign r_line_base = MB'({req_reg.word_addr >> OFFL, {OFFL{1'b0}}});

    function automatic logic [LB-1:0] slot(input logic [SB-1:0] s, input logic [WB-1:0] w);
        slot = LB'(32'(s) * WAYS + 32'(w));
    endfunction

    // tag entry fields: {valid, dirty, ref, tag}
    logic hit_any;
    logic [WB-1:0] hit_way;
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (line_reg[w][TAGW-1] && line_reg[w][TB-1:0] == r_tag) begin
                hit_any = 1'b1;
                hit_way = WB'(w);
            end
        end
    end

    logic [LB-1:0] cur_slot;
    logic [DB-1:0] dslot;
    logic [TAGW-1:0] vic;
    logic [MB-1:0] wb_addr;
    logic [WB-1:0] way_inc;
    assign cur_slot = slot(r_set, way_reg);
    assign dslot = DB'(32'(cur_slot) * LINE_WORDS + 32'(idx_reg[OB-1:0]));
    assign vic = line_reg[way_reg];
    assign wb_addr = MB'(((32'(vic[TB-1:0]) * SETS + 32'(r_set)) * LINE_WORDS)
                     + 32'(idx_reg[OB-1:0]));
    // next way around the set, wrapping at the last way
    assign way_inc = (32'(way_reg) == WAYS - 1) ? '0 : way_reg + 1'b1;

    logic last_word;
    assign last_word = (32'(idx_reg) == LINE_WORDS - 1);

    assign q_pop = (state_reg == ST_IDLE) && q_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_value = res_v_reg;
    assign res_outcome = res_o_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (32'(clr_reg) == ((MEMORY_WORDS > WAYS*SETS) ? MEMORY_WORDS :
                                             WAYS*SETS) - 1)
                            state_next = ST_IDLE;
            ST_IDLE:    if (q_valid && !res_valid_reg) state_next = ST_LOOK;
            ST_LOOK:    if (32'(wcnt_reg) == WAYS - 1) state_next = ST_HITRD;
            ST_HITRD:   state_next = hit_any ? ST_RDOUT : ST_VICTIM;
            ST_VICTIM:  if (!line_reg[way_reg][TAGW-3])
                            state_next = (vic[TAGW-1] && vic[TAGW-2]) ? ST_WB_RD : ST_FILL_RD;
            ST_WB_RD:   state_next = ST_WB_WR;
            ST_WB_WR:   state_next = last_word ? ST_FILL_RD : ST_WB_RD;
            ST_FILL_RD: state_next = ST_FILL_WR;
            ST_FILL_WR: state_next = last_word ? ST_FINISH : ST_FILL_RD;
            ST_FINISH:  state_next = ST_RDOUT;
            ST_RDOUT:   state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_DONE) res_valid_reg <= 1'b1;
        end
        case (state_reg)
            ST_CLEAR: begin
                if (32'(clr_reg) < MEMORY_WORDS) back_mem[MB'(clr_reg)] <= '0;
                if (32'(clr_reg) < WAYS * SETS)  tag_mem[LB'(clr_reg)] <= '0;
                if (32'(clr_reg) < SETS)         ptr_mem[SB'(clr_reg)] <= '0;
            end
            ST_IDLE: begin
                req_reg  <= q_req;
                way_reg  <= '0;
                wcnt_reg <= '0;
                idx_reg  <= '0;
            end
            ST_LOOK: begin
                line_reg[wcnt_reg] <= tag_mem[slot(r_set, wcnt_reg)];
                ptr_reg <= ptr_mem[r_set];
                wcnt_reg <= WB'(32'(wcnt_reg) + 1);
            end
            ST_HITRD: begin
                way_reg <= hit_any ? hit_way : ptr_reg;
                res_o_reg <= OUT_HIT;
                if (hit_any) begin
                    idx_reg <= {1'b0, r_off};
                    tag_mem[slot(r_set, hit_way)] <= req_reg.is_write ?
                        (line_reg[hit_way] | TAGW'(1) << (TAGW-2)) :
                        (line_reg[hit_way] | TAGW'(1) << (TAGW-3));
                end
            end
            ST_VICTIM: begin
                if (line_reg[way_reg][TAGW-3]) begin
                    line_reg[way_reg][TAGW-3] <= 1'b0;
                    tag_mem[cur_slot] <= vic & ~(TAGW'(1) << (TAGW-3));
                    way_reg <= way_inc;
                end else begin
                    ptr_mem[r_set] <= way_inc;
                    res_o_reg <= (vic[TAGW-1] && vic[TAGW-2]) ? OUT_DIRTY : OUT_CLEAN;
                end
            end
            ST_WB_RD: drd_reg <= data_mem[dslot];
            ST_WB_WR: begin
                back_mem[wb_addr] <= drd_reg;
                idx_reg <= last_word ? '0 : idx_reg + 1'b1;
            end
            ST_FILL_RD: brd_reg <= back_mem[MB'(r_line_base + MB'(idx_reg[OB-1:0]))];
            ST_FILL_WR: begin
                data_mem[dslot] <= brd_reg;
                idx_reg <= last_word ? {1'b0, r_off} : idx_reg + 1'b1;
            end
            ST_FINISH: begin
                tag_mem[cur_slot] <= {1'b1, req_reg.is_write, 1'b0, r_tag};
            end
            ST_RDOUT: begin
                if (req_reg.is_write) data_mem[dslot] <= req_reg.wval;
                else drd_reg <= data_mem[dslot];
            end
            ST_DONE: res_v_reg <= req_reg.is_write ? 32'd0 : drd_reg;
            default: ;
        endcase
    end
endmodule

@@ sv/fwsc_checker.sv @@
// ----------------------------------------------------------------------------
// fwsc_checker
// port-level checks on the cache core
// ----------------------------------------------------------------------------
module fwsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // outcome code is never three
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad outcome");
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed");
    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0) else $error("pad");
    // no result in the cycle after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("valid after reset");
    // request ready is always known while a request is offered
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid |-> !$isunknown(s_axis_tready)) else $error("ready unknown");
endmodule

bind four_way_second_chance_cache_core fwsc_checker u_fwsc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the four-way second-chance cache core
// ----------------------------------------------------------------------------
// Word reads and writes go in over the request stream. A model of the cache
// and its backing memory in the bench works out the read word and the
// outcome of every transfer. Each result is checked in order against it.
// Most random traffic packs into a few sets, so that hits, clock-pointer
// skips, clean fills and dirty writebacks all happen often.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fwsc_pkg::*;

    localparam int NWAYS  = 4;
    localparam int NSETS  = 1024;
    localparam int NWORDS = 16;
    localparam int NMEM   = 1048576;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  outcome;
    } cache_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;  // mode, byte_address, write_value
    logic        m_axis_tready = 1'b0;
    logic        m_axis_tvalid;
    logic [39:0] m_axis_tdata;       // read_value, outcome

    // bench copy of the cache and memory state
    logic [5:0]  way_tag   [NWAYS*NSETS];
    bit          way_valid [NWAYS*NSETS];
    bit          way_dirty [NWAYS*NSETS];
    bit          way_ref   [NWAYS*NSETS];
    bit   [1:0]  hand      [NSETS];
    logic [31:0] cached    [NWAYS*NSETS*NWORDS];
    bit   [31:0] dram      [NMEM];

    cache_result_t pending_results[$];
    int  errors = 0;
    int  cycles = 0;
    int  sent = 0;
    int  checked = 0;
    bit  idles_on = 1'b1;
    int  holdoff = 0;

    four_way_second_chance_cache_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // compute what one access returns and update the bench state
    function automatic cache_result_t access_cache(bit wr, logic [21:0] addr,
                                                   logic [31:0] wval);
        cache_result_t r;
        logic [19:0] waddr;
        logic [3:0]  off;
        logic [9:0]  set;
        logic [5:0]  tag;
        int base, slot, p, n, old;
        bit hit;
        waddr = addr[21:2];
        off = waddr[3:0];
        set = waddr[13:4];
        tag = waddr[19:14];
        base = set * NWAYS;
        r = '0;
        hit = 1'b0;
        slot = base;
        for (int w = 0; w < NWAYS; w++) begin
            if (!hit && way_valid[base+w] && way_tag[base+w] == tag) begin
                hit = 1'b1;
                slot = base + w;
            end
        end
        if (hit) begin
            r.outcome = OUT_HIT;
            if (wr) begin
                cached[slot*NWORDS+off] = wval;
                way_dirty[slot] = 1'b1;
            end else begin
                r.read_value = cached[slot*NWORDS+off];
                way_ref[slot] = 1'b1;
            end
        end else begin
            // clock hand gives referenced ways a second chance
            p = hand[set];
            for (n = 0; n <= NWAYS; n++) begin
                if (!way_ref[base+p]) break;
                way_ref[base+p] = 1'b0;
                p = (p + 1) % NWAYS;
            end
            slot = base + p;
            hand[set] = 2'((p + 1) % NWAYS);
            r.outcome = OUT_CLEAN;
            if (way_valid[slot] && way_dirty[slot]) begin
                old = (way_tag[slot] * NSETS + set) * NWORDS;
                for (int i = 0; i < NWORDS; i++)
                    dram[(old + i) % NMEM] = cached[slot*NWORDS+i];
                r.outcome = OUT_DIRTY;
            end
            for (int i = 0; i < NWORDS; i++)
                cached[slot*NWORDS+i] = dram[(waddr[19:4] * NWORDS + i) % NMEM];
            way_tag[slot] = tag;
            way_valid[slot] = 1'b1;
            way_ref[slot] = 1'b0;
            if (wr) begin
                cached[slot*NWORDS+off] = wval;
                way_dirty[slot] = 1'b1;
            end else begin
                r.read_value = cached[slot*NWORDS+off];
                way_dirty[slot] = 1'b0;
            end
        end
        return r;
    endfunction

    // offer one request, wait for its transfer, then record the prediction
    task automatic send_access(bit wr, logic [21:0] addr, logic [31:0] wval);
        if (idles_on && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, wval, addr, wr};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_results.push_back(access_cache(wr, addr, wval));
        sent++;
    endtask

    // random address inside a small pool of sets, so lines collide
    function automatic logic [21:0] crowded_addr();
        logic [9:0] set;
        logic [5:0] tag;
        case ($urandom_range(3))
            0: set = 10'd0;
            1: set = 10'h3FF;
            2: set = 10'd517;
            default: set = 10'($urandom_range(8, 11));
        endcase
        tag = 6'($urandom_range(7)) | ($urandom_range(9) == 0 ? 6'($urandom) : 6'd0);
        return {tag, set, 4'($urandom), 2'($urandom)};
    endfunction

    // receiver: random stalls, long hold-off on request, in-order check
    always @(posedge aclk) begin
        if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idles_on && $urandom_range(99) < 7);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                cache_result_t e;
                e = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== e.read_value) begin
                    $error("read_value expected %h actual %h",
                           e.read_value, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[33:32] !== e.outcome) begin
                    $error("outcome expected %0d actual %0d",
                           e.outcome, m_axis_tdata[33:32]);
                    errors++;
                end
                checked++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed();
        send_access(1'b0, 22'h000000, 32'h0);           // cold read at zero
        send_access(1'b0, 22'h3FFFFF, 32'hFFFFFFFF);    // top address, read
        send_access(1'b1, 22'h3FFFFF, 32'hFFFFFFFF);    // write hit, max value
        send_access(1'b0, 22'h3FFFFC, 32'h0);           // same word, low bits differ
        send_access(1'b1, 22'h000004, 32'hA5A5A5A5);    // write hit
        send_access(1'b0, 22'h000007, 32'h0);           // read hit, sets reference
        send_access(1'b1, 22'h000000, 32'h00000000);    // write zero
        // fill set zero and go past its four ways: dirty eviction
        for (int t = 1; t <= 5; t++)
            send_access(t[0], {6'(t), 10'd0, 4'(t), 2'b00}, 32'h1000_0000 + t);
        // read one line to give it a second chance, then miss again
        send_access(1'b0, {6'd4, 10'd0, 4'd4, 2'b00}, 32'h0);
        send_access(1'b0, {6'd9, 10'd0, 4'd0, 2'b00}, 32'h0);
        send_access(1'b0, {6'd10, 10'd0, 4'd0, 2'b00}, 32'h0);
        // read back evicted data from memory
        send_access(1'b0, {6'd1, 10'd0, 4'd1, 2'b00}, 32'h0);
        send_access(1'b0, 22'h000004, 32'h0);
        send_access(1'b1, {6'h3F, 10'h3FF, 4'hF, 2'b11}, 32'h5555AAAA);
        send_access(1'b0, {6'h3F, 10'h3FF, 4'hF, 2'b00}, 32'h0);
    endtask

    task automatic test_crowded_random(int count);
        for (int i = 0; i < count; i++)
            send_access(1'($urandom_range(1)), crowded_addr(), $urandom);
    endtask

    task automatic test_wide_random(int count);
        for (int i = 0; i < count; i++)
            send_access(1'($urandom_range(1)), 22'($urandom), $urandom);
    endtask

    task automatic test_no_idles(int count);
        idles_on = 1'b0;
        test_crowded_random(count);
        idles_on = 1'b1;
    endtask

    task automatic test_backpressure(int count);
        holdoff = 600;
        test_crowded_random(count);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_crowded_random(700);
        test_wide_random(250);
        test_no_idles(250);
        test_backpressure(40);
        test_crowded_random(210);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d accesses, %0d results checked: hits, clean fills,", sent, checked);
        $display("dirty writebacks, clock skips, idle gaps and a long output stall");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ four_way_second_chance_cache_core.f @@
sv/fwsc_pkg.sv
sv/fwsc_front.sv
sv/fwsc_back.sv
sv/four_way_second_chance_cache_core.sv
sv/fwsc_checker.sv
sim/tb_top.sv
